FILE: rtl/dwrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwrb_pkg
// shared types and codes of the draw-without-replacement bag
// ----------------------------------------------------------------------------
package dwrb_pkg;

    // request modes
    localparam logic MODE_REFILL = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_FILL = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_RD1  = 7'b0001000,
        ST_RD2  = 7'b0010000,
        ST_WR   = 7'b0100000,
        ST_OUT  = 7'b1000000
    } dwrb_state_t;

endpackage
`default_nettype wire

FILE: rtl/dwrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwrb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dwrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/draw_without_replacement_bag_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// draw_without_replacement_bag_unit
// bag of the values 0 .. bag_size-1 drawn without replacement (fisher-yates)
// ----------------------------------------------------------------------------
// draw: 16 restoring remainder steps, then two reads on the single-read-port
//   bag ram (drawn slot, last slot), a write-back and, once m_ is free, the output register load
// refill: one ram write per cycle into slots 0 .. n-1, n = min(bag_size, BAG_DEPTH);
//   an empty draw or a size-zero refill skips the ram and goes straight to the output
// one request in flight; the next is taken while the result waits at m_;
//   reset clears control state, not the ram
// ----------------------------------------------------------------------------
module draw_without_replacement_bag_unit
    import dwrb_pkg::*;
#(
    parameter int BAG_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_bag_size,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [15:0] s_random_word,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_drawn_value,
    output logic             m_bag_empty,
    output logic [7:0]       m_remaining_count
);

    localparam int         AW      = $clog2(BAG_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(BAG_DEPTH);

    // control state
    dwrb_state_t state_reg, state_next;
    logic [7:0]  live_reg, live_next;         // live entries in the bag
    logic [7:0]  fill_reg, fill_next;         // refill write pointer
    logic [3:0]  step_reg, step_next;         // remainder step counter
    logic [7:0]  bag_size_reg;
    logic        m_valid_reg, m_valid_next;

    // datapath
    logic [15:0] dividend_reg, dividend_next;
    logic [7:0]  rem_reg, rem_next;           // running remainder, ends as slot
    logic [7:0]  value_reg, value_next;
    logic        empty_reg, empty_next;
    logic [7:0]  m_value_reg, m_value_next;
    logic        m_empty_reg, m_empty_next;
    logic [7:0]  m_count_reg, m_count_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [7:0]  fill_target;                 // min(bag_size, depth)
    logic [8:0]  rem_shift;
    logic [7:0]  last_slot;
    logic        in_accept;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_drawn_value     = m_value_reg;
    assign m_bag_empty       = m_empty_reg;
    assign m_remaining_count = m_count_reg;

    // refill loads at most the ram depth
    assign fill_target = ({1'b0, bag_size_reg} > DEPTH_W) ? DEPTH_W[7:0] : bag_size_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dividend_reg[15]};
    assign last_slot = live_reg - 8'd1;

    // ram access: refill writes i into slot i, a draw moves the last entry
    // into the drawn slot after both reads are back
    assign ram_we    = (state_reg == ST_FILL) || (state_reg == ST_WR);
    assign ram_waddr = (state_reg == ST_FILL) ? fill_reg[AW-1:0] : rem_reg[AW-1:0];
    assign ram_wdata = (state_reg == ST_FILL) ? fill_reg : ram_rdata;
    assign ram_raddr = (state_reg == ST_RD1) ? rem_reg[AW-1:0] : last_slot[AW-1:0];

    dwrb_ram #(
        .WIDTH (8),
        .DEPTH (BAG_DEPTH)
    ) u_bag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        live_next     = live_reg;
        fill_next     = fill_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        value_next    = value_reg;
        empty_next    = empty_reg;
        m_value_next  = m_value_reg;
        m_empty_next  = m_empty_reg;
        m_count_next  = m_count_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    value_next = 8'd0;
                    empty_next = 1'b0;
                    if (s_mode == MODE_REFILL) begin
                        live_next = fill_target;
                        fill_next = 8'd0;
                        // size zero empties the bag with no writes
                        state_next = (fill_target == 8'd0) ? ST_OUT : ST_FILL;
                    end else if (live_reg == 8'd0) begin
                        // empty draw leaves the state alone
                        empty_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        dividend_next = s_random_word;
                        rem_next      = 8'd0;
                        step_next     = 4'd0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_FILL: begin
                fill_next = fill_reg + 8'd1;
                if (fill_reg == last_slot) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (rem_shift >= {1'b0, live_reg}) begin
                    rem_next = 8'(rem_shift - {1'b0, live_reg});
                end else begin
                    rem_next = rem_shift[7:0];
                end
                dividend_next = {dividend_reg[14:0], 1'b0};
                step_next     = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1: begin
                state_next = ST_RD2;
            end
            ST_RD2: begin
                // drawn slot's entry is back
                value_next = ram_rdata;
                state_next = ST_WR;
            end
            ST_WR: begin
                live_next  = last_slot;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = value_reg;
                    m_empty_next = empty_reg;
                    m_count_next = live_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            live_reg     <= 8'd0;
            fill_reg     <= 8'd0;
            step_reg     <= 4'd0;
            bag_size_reg <= 8'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            fill_reg    <= fill_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                bag_size_reg <= cfg_bag_size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        value_reg    <= value_next;
        empty_reg    <= empty_next;
        m_value_reg  <= m_value_next;
        m_empty_reg  <= m_empty_next;
        m_count_reg  <= m_count_next;
    end

    // live count never exceeds the ram depth
    a_live_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, live_reg} <= DEPTH_W)
        else $error("live count above bag depth");

    // refill pointer stays below the live count while filling
    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (fill_reg < live_reg))
        else $error("refill pointer out of range");

    // running remainder stays below the divisor
    a_rem_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < live_reg))
        else $error("remainder not reduced");

    // write-back only follows both reads
    a_wr_after_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR) |-> ($past(state_reg) == ST_RD2))
        else $error("write-back without read");

    // an empty draw reports no value and an empty bag
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_value_reg == 8'd0 && m_count_reg == 8'd0))
        else $error("empty draw result inconsistent");

endmodule
`default_nettype wire
